[sv/fasta_record_parser_unit_defines.svh]
// ---------------------------------------------------------------------------
// FASTA record parser assertion macros
// Shared concurrent assertion forms used by the parser RTL.
// ---------------------------------------------------------------------------
`ifndef FASTA_RECORD_PARSER_UNIT_DEFINES_SVH
`define FASTA_RECORD_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FRP_ASSERT_NOW(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("parser check failed");

// Next-cycle implication, checked outside reset.
`define FRP_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("parser check failed");

`endif

[sv/frp_pkg.sv]
// ---------------------------------------------------------------------------
// FASTA record parser package
// Types, codes and constants shared by the parser modules.
// ---------------------------------------------------------------------------
package frp_pkg;

    localparam int CNT_W     = 31;
    localparam int DEF_CAP_W = 17;
    localparam int SEQ_CAP_W = 31;
    localparam int CHAR_W    = 8;
    localparam int CFG_IDX_W = 2;

    // Counters saturate here.
    localparam logic [CNT_W-1:0] COUNT_LIMIT = 31'h7fffffff;

    localparam logic [DEF_CAP_W-1:0] DEF_CAP_RESET = 17'd256;
    localparam logic [SEQ_CAP_W-1:0] SEQ_CAP_RESET = 31'd1048576;

    // Character constants.
    localparam logic [CHAR_W-1:0] CHAR_GT    = 8'h3e;
    localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0a;
    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0d;
    localparam logic [CHAR_W-1:0] CHAR_U     = 8'h75;
    localparam logic [CHAR_W-1:0] CHAR_T     = 8'h74;
    localparam logic [CHAR_W-1:0] CASE_BIT   = 8'h20;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEF_CAPACITY = 2'd0,
        CFG_SEQ_CAPACITY = 2'd1
    } t_cfg_index;

    typedef enum logic [2:0] {
        PH_EXPECT  = 3'd0,
        PH_PRE_ID  = 3'd1,
        PH_ID      = 3'd2,
        PH_PRE_DEF = 3'd3,
        PH_DEF     = 3'd4,
        PH_SEQ     = 3'd5,
        PH_ERROR   = 3'd6
    } t_phase;

    typedef enum logic [2:0] {
        KIND_ID_CHAR    = 3'd0,
        KIND_DEF_CHAR   = 3'd1,
        KIND_BASE       = 3'd2,
        KIND_RECORD_END = 3'd3,
        KIND_STREAM_END = 3'd4,
        KIND_ERROR      = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        ERR_NONE       = 2'd0,
        ERR_NO_MARKER  = 2'd1,
        ERR_UNNAMED    = 2'd2
    } t_error;

    typedef struct packed {
        logic [DEF_CAP_W-1:0] def_capacity;
        logic [SEQ_CAP_W-1:0] seq_capacity;
    } t_cfg;

    typedef struct packed {
        t_phase           phase;
        logic [CNT_W-1:0] id_count;
        logic [CNT_W-1:0] def_count;
        logic [CNT_W-1:0] base_count;
        logic             overflow_seen;
    } t_parse_state;

    typedef struct packed {
        logic              valid;
        t_kind             kind;
        logic [CHAR_W-1:0] char_out;
        logic [CNT_W-1:0]  char_index;
        logic [CNT_W-1:0]  seq_stored;
        logic [CNT_W-1:0]  seq_total;
        logic [CNT_W-1:0]  def_total;
        logic              def_truncated;
        logic              seq_truncated;
        logic              seq_overflow;
        t_error            error_code;
    } t_result;

endpackage

[sv/frp_cfg.sv]
// ---------------------------------------------------------------------------
// FASTA parser configuration registers
// Decodes configuration write transactions into the capacity registers.
// ---------------------------------------------------------------------------
module frp_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [frp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [frp_pkg::SEQ_CAP_W-1:0]   i_cfg_data,
    output frp_pkg::t_cfg                   o_cfg
);

    frp_pkg::t_cfg r_cfg;
    frp_pkg::t_cfg n_cfg;

    // Writes are always taken; unknown indexes are dropped.
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Register decode.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                frp_pkg::CFG_DEF_CAPACITY: begin
                    n_cfg.def_capacity = i_cfg_data[frp_pkg::DEF_CAP_W-1:0];
                end
                frp_pkg::CFG_SEQ_CAPACITY: begin
                    n_cfg.seq_capacity = i_cfg_data;
                end
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    // Capacity registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{def_capacity: frp_pkg::DEF_CAP_RESET,
                       seq_capacity: frp_pkg::SEQ_CAP_RESET};
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

[sv/frp_step.sv]
// ---------------------------------------------------------------------------
// FASTA parser step logic
// Combinational phase and counter update for one byte or end-of-stream item.
// ---------------------------------------------------------------------------
module frp_step (
    input  frp_pkg::t_parse_state               i_state,
    input  frp_pkg::t_cfg                       i_cfg,
    input  logic [frp_pkg::CHAR_W-1:0]          i_byte_in,
    input  logic                                i_end_of_stream,
    output frp_pkg::t_parse_state               o_next_state,
    output frp_pkg::t_result                    o_result
);

    logic                         is_blank;
    logic                         is_letter;
    logic                         id_sat;
    logic                         def_sat;
    logic                         base_sat;
    logic [frp_pkg::CNT_W-1:0]    id_inc;
    logic [frp_pkg::CNT_W-1:0]    def_inc;
    logic [frp_pkg::CNT_W-1:0]    base_inc;
    logic                         def_keep;
    logic                         base_keep;
    logic [frp_pkg::CHAR_W-1:0]   base_char;
    logic [frp_pkg::CHAR_W-1:0]   lower_char;
    logic [frp_pkg::SEQ_CAP_W-1:0] seq_cap_m1;
    logic [frp_pkg::CNT_W-1:0]    stored;
    frp_pkg::t_parse_state        cleared;
    frp_pkg::t_result             blank_result;

    // Byte classes.
    assign is_blank  = (i_byte_in == frp_pkg::CHAR_SPACE) ||
                       ((i_byte_in >= frp_pkg::CHAR_TAB) && (i_byte_in <= frp_pkg::CHAR_CR));
    assign is_letter = ((i_byte_in >= 8'h41) && (i_byte_in <= 8'h5a)) ||
                       ((i_byte_in >= 8'h61) && (i_byte_in <= 8'h7a));

    // Saturating counter increments.
    assign id_sat   = (i_state.id_count >= frp_pkg::COUNT_LIMIT);
    assign def_sat  = (i_state.def_count >= frp_pkg::COUNT_LIMIT);
    assign base_sat = (i_state.base_count >= frp_pkg::COUNT_LIMIT);
    assign id_inc   = i_state.id_count + 31'd1;
    assign def_inc  = i_state.def_count + 31'd1;
    assign base_inc = i_state.base_count + 31'd1;

    // A character is kept while its 1-based count is below the capacity.
    assign def_keep  = ({14'd0, i_cfg.def_capacity} > def_inc);
    assign base_keep = (i_cfg.seq_capacity > base_inc);

    // Bases are lowercased, with u folded onto t.
    assign lower_char = i_byte_in | frp_pkg::CASE_BIT;
    assign base_char  = (lower_char == frp_pkg::CHAR_U) ? frp_pkg::CHAR_T : lower_char;

    // Record summary: bases stored is min(count, capacity - 1), or 0 without capacity.
    assign seq_cap_m1 = i_cfg.seq_capacity - 31'd1;
    assign stored = (i_cfg.seq_capacity == '0) ? '0 :
                    ((i_state.base_count < seq_cap_m1) ? i_state.base_count : seq_cap_m1);

    always_comb begin
        cleared               = '0;
        cleared.phase         = frp_pkg::PH_EXPECT;
        blank_result          = '0;
        blank_result.kind     = frp_pkg::KIND_ID_CHAR;
        blank_result.error_code = frp_pkg::ERR_NONE;
    end

    // Phase transition and result selection.
    always_comb begin
        o_next_state = i_state;
        o_result     = blank_result;

        if (i_end_of_stream) begin
            unique case (i_state.phase)
                frp_pkg::PH_PRE_ID: begin
                    o_next_state          = cleared;
                    o_result.valid        = 1'b1;
                    o_result.kind         = frp_pkg::KIND_ERROR;
                    o_result.error_code   = frp_pkg::ERR_UNNAMED;
                end
                frp_pkg::PH_ID, frp_pkg::PH_PRE_DEF, frp_pkg::PH_DEF, frp_pkg::PH_SEQ: begin
                    o_next_state           = cleared;
                    o_result.valid         = 1'b1;
                    o_result.kind          = frp_pkg::KIND_RECORD_END;
                    o_result.seq_stored    = stored;
                    o_result.seq_total     = i_state.base_count;
                    o_result.def_total     = i_state.def_count;
                    o_result.def_truncated = (i_state.def_count >=
                                              {14'd0, i_cfg.def_capacity});
                    o_result.seq_truncated = (i_state.base_count >= i_cfg.seq_capacity);
                    o_result.seq_overflow  = i_state.overflow_seen;
                end
                default: begin
                    // Expecting a marker, or recovering from an error.
                    o_next_state   = cleared;
                    o_result.valid = 1'b1;
                    o_result.kind  = frp_pkg::KIND_STREAM_END;
                end
            endcase
        end else begin
            unique case (i_state.phase)
                frp_pkg::PH_EXPECT: begin
                    if (i_byte_in == frp_pkg::CHAR_GT) begin
                        o_next_state       = cleared;
                        o_next_state.phase = frp_pkg::PH_PRE_ID;
                    end else begin
                        o_next_state        = cleared;
                        o_next_state.phase  = frp_pkg::PH_ERROR;
                        o_result.valid      = 1'b1;
                        o_result.kind       = frp_pkg::KIND_ERROR;
                        o_result.error_code = frp_pkg::ERR_NO_MARKER;
                    end
                end
                frp_pkg::PH_PRE_ID, frp_pkg::PH_ID: begin
                    priority if (i_byte_in == frp_pkg::CHAR_LF) begin
                        if (i_state.phase == frp_pkg::PH_PRE_ID) begin
                            o_next_state        = cleared;
                            o_next_state.phase  = frp_pkg::PH_ERROR;
                            o_result.valid      = 1'b1;
                            o_result.kind       = frp_pkg::KIND_ERROR;
                            o_result.error_code = frp_pkg::ERR_UNNAMED;
                        end else begin
                            o_next_state.phase = frp_pkg::PH_SEQ;
                        end
                    end else if (is_blank) begin
                        if (i_state.phase == frp_pkg::PH_ID) begin
                            o_next_state.phase = frp_pkg::PH_PRE_DEF;
                        end
                    end else begin
                        o_next_state.phase    = frp_pkg::PH_ID;
                        o_next_state.id_count = id_sat ? i_state.id_count : id_inc;
                        o_result.valid        = 1'b1;
                        o_result.kind         = frp_pkg::KIND_ID_CHAR;
                        o_result.char_out     = i_byte_in;
                        o_result.char_index   = i_state.id_count;
                    end
                end
                frp_pkg::PH_PRE_DEF, frp_pkg::PH_DEF: begin
                    priority if (i_byte_in == frp_pkg::CHAR_LF) begin
                        o_next_state.phase = frp_pkg::PH_SEQ;
                    end else if ((i_state.phase == frp_pkg::PH_DEF) &&
                                 (i_byte_in == frp_pkg::CHAR_NUL)) begin
                        o_next_state.phase = frp_pkg::PH_SEQ;
                    end else if ((i_state.phase == frp_pkg::PH_PRE_DEF) && is_blank) begin
                        o_next_state.phase = frp_pkg::PH_PRE_DEF;
                    end else begin
                        o_next_state.phase = frp_pkg::PH_DEF;
                        if (!def_sat) begin
                            o_next_state.def_count = def_inc;
                            o_result.valid         = def_keep;
                            o_result.kind          = frp_pkg::KIND_DEF_CHAR;
                            o_result.char_out      = i_byte_in;
                            o_result.char_index    = i_state.def_count;
                        end
                    end
                end
                frp_pkg::PH_SEQ: begin
                    priority if (i_byte_in == frp_pkg::CHAR_GT) begin
                        o_next_state           = cleared;
                        o_next_state.phase     = frp_pkg::PH_PRE_ID;
                        o_result.valid         = 1'b1;
                        o_result.kind          = frp_pkg::KIND_RECORD_END;
                        o_result.seq_stored    = stored;
                        o_result.seq_total     = i_state.base_count;
                        o_result.def_total     = i_state.def_count;
                        o_result.def_truncated = (i_state.def_count >=
                                                  {14'd0, i_cfg.def_capacity});
                        o_result.seq_truncated = (i_state.base_count >= i_cfg.seq_capacity);
                        o_result.seq_overflow  = i_state.overflow_seen;
                    end else if (!is_letter) begin
                        o_next_state.phase = frp_pkg::PH_SEQ;
                    end else if (base_sat) begin
                        o_next_state.overflow_seen = 1'b1;
                    end else begin
                        o_next_state.base_count = base_inc;
                        o_result.valid          = base_keep;
                        o_result.kind           = frp_pkg::KIND_BASE;
                        o_result.char_out       = base_char;
                        o_result.char_index     = i_state.base_count;
                    end
                end
                default: begin
                    // Error recovery and unused codes: bytes are dropped.
                    o_next_state.phase = frp_pkg::PH_ERROR;
                end
            endcase
        end
    end

endmodule

[sv/fasta_record_parser_unit.sv]
// The parser takes one FASTA byte (or an end-of-stream mark) per input
// transaction and gives at most one result transaction for it: an identifier
// character, a definition character, a base, a record summary, a stream end
// or an error. A byte can be accepted in every clock cycle while the result
// channel does not stall. Each byte is captured in the input register, and
// its result is loaded into the result register when that register is free
// or draining. The combinational phase and counter update between those two
// registers sets the rate of one byte per cycle when the output is not held.
// While a finished result waits for i_out_ready, the input register still
// takes one byte and holds it, and the input then stalls until the result is
// taken. Capacity registers are written through the configuration channel,
// which is always ready.
// ---------------------------------------------------------------------------
// FASTA record parser top level
// Input register, parse step, state registers and result register.
// ---------------------------------------------------------------------------
`include "fasta_record_parser_unit_defines.svh"

module fasta_record_parser_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration write channel.
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [frp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [frp_pkg::SEQ_CAP_W-1:0]   i_cfg_data,
    // Byte input channel.
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [frp_pkg::CHAR_W-1:0]      i_byte_in,
    input  logic                            i_end_of_stream,
    // Result channel.
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [2:0]                      o_kind,
    output logic [frp_pkg::CHAR_W-1:0]      o_char_out,
    output logic [frp_pkg::CNT_W-1:0]       o_char_index,
    output logic [frp_pkg::CNT_W-1:0]       o_seq_stored,
    output logic [frp_pkg::CNT_W-1:0]       o_seq_total,
    output logic [frp_pkg::CNT_W-1:0]       o_def_total,
    output logic                            o_def_truncated,
    output logic                            o_seq_truncated,
    output logic                            o_seq_overflow,
    output logic [1:0]                      o_error_code
);

    frp_pkg::t_cfg                  cfg;
    frp_pkg::t_parse_state          r_state;
    frp_pkg::t_parse_state          n_state;
    frp_pkg::t_result               step_result;
    frp_pkg::t_result               r_out;
    logic                           r_in_valid;
    logic [frp_pkg::CHAR_W-1:0]     r_byte;
    logic                           r_eos;
    logic                           r_out_valid;
    logic                           step_fire;
    logic                           in_fire;

    frp_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    frp_step u_step (
        .i_state         (r_state),
        .i_cfg           (cfg),
        .i_byte_in       (r_byte),
        .i_end_of_stream (r_eos),
        .o_next_state    (n_state),
        .o_result        (step_result)
    );

    // The held item advances whenever the result register is free or draining.
    assign step_fire  = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || step_fire;
    assign in_fire    = i_in_valid && o_in_ready;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (step_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_byte <= i_byte_in;
            r_eos  <= i_end_of_stream;
        end
    end

    // Parse state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{phase: frp_pkg::PH_EXPECT, id_count: '0, def_count: '0,
                         base_count: '0, overflow_seen: 1'b0};
        end else if (step_fire) begin
            r_state <= n_state;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step_fire) begin
            r_out_valid <= step_result.valid;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_fire && step_result.valid) begin
            r_out <= step_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_kind          = r_out.kind;
    assign o_char_out      = r_out.char_out;
    assign o_char_index    = r_out.char_index;
    assign o_seq_stored    = r_out.seq_stored;
    assign o_seq_total     = r_out.seq_total;
    assign o_def_total     = r_out.def_total;
    assign o_def_truncated = r_out.def_truncated;
    assign o_seq_truncated = r_out.seq_truncated;
    assign o_seq_overflow  = r_out.seq_overflow;
    assign o_error_code    = r_out.error_code;

    // A held item that cannot advance stays held.
    `FRP_ASSERT_NEXT(a_in_held, i_clk, i_rst_n, r_in_valid && !step_fire, r_in_valid)

    // An error result always carries a nonzero error code.
    `FRP_ASSERT_NOW(a_err_code, i_clk, i_rst_n,
        r_out_valid && (r_out.kind == frp_pkg::KIND_ERROR),
        r_out.error_code != frp_pkg::ERR_NONE)

    // A record summary never stores more bases than it counted.
    `FRP_ASSERT_NOW(a_stored_le_total, i_clk, i_rst_n,
        r_out_valid && (r_out.kind == frp_pkg::KIND_RECORD_END),
        r_out.seq_stored <= r_out.seq_total)

    // Closing a record clears every record counter.
    `FRP_ASSERT_NEXT(a_record_cleared, i_clk, i_rst_n,
        step_fire && step_result.valid && (step_result.kind == frp_pkg::KIND_RECORD_END),
        (r_state.base_count == '0) && (r_state.def_count == '0) && !r_state.overflow_seen)

endmodule
